/* rtl/command_frame_builder_crc8_crc16_assert.svh */
// Assertion macros for the command frame builder checkers.
`ifndef COMMAND_FRAME_BUILDER_CRC8_CRC16_ASSERT_SVH
`define COMMAND_FRAME_BUILDER_CRC8_CRC16_ASSERT_SVH

// Clocked check, disabled while reset is asserted.
`define CFB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cfb check failed");

// Clocked check that also runs across reset.
`define CFB_ASSERT_ANY(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("cfb check failed");

`endif

/* rtl/cfb_pkg.sv */
// Types, constants and CRC functions shared by the command frame builder.
package cfb_pkg;

    localparam logic [7:0]  SYNC_BYTE     = 8'h55;
    localparam logic [7:0]  VERSION_BITS  = 8'h04;
    localparam logic [1:0]  LEN_HIGH_MASK = 2'h3;
    localparam logic [9:0]  OVERHEAD      = 10'd13;
    localparam logic [9:0]  MAX_PAYLOAD   = 10'd1010;
    localparam logic [7:0]  CRC8_INIT     = 8'h77;
    localparam logic [7:0]  CRC8_POLY     = 8'h8C;
    localparam logic [15:0] CRC16_INIT    = 16'h3692;
    localparam logic [15:0] CRC16_POLY    = 16'h8408;

    typedef struct packed {
        logic [7:0]  sender;
        logic [7:0]  receiver;
        logic [15:0] sequence_req;
        logic [7:0]  msg_flags;
        logic [7:0]  command_set;
        logic [7:0]  command_id;
        logic [9:0]  payload_len;
        logic [7:0]  payload_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } result_t;

    // One classified beat handed from the front end to the back end.
    typedef struct packed {
        logic        header;
        logic        has_payload;
        logic        close;
        logic [7:0]  len_lo;
        logic [7:0]  len_hi;
        logic [7:0]  hdr_crc;
        logic [7:0]  sender;
        logic [7:0]  receiver;
        logic [15:0] sequence_req;
        logic [7:0]  msg_flags;
        logic [7:0]  command_set;
        logic [7:0]  command_id;
        logic [7:0]  payload_byte;
    } cmd_t;

    typedef enum logic [13:0] {
        S_SYNC     = 14'h0001,
        S_LEN_LO   = 14'h0002,
        S_LEN_HI   = 14'h0004,
        S_HCRC     = 14'h0008,
        S_SENDER   = 14'h0010,
        S_RECEIVER = 14'h0020,
        S_SEQ_HI   = 14'h0040,
        S_SEQ_LO   = 14'h0080,
        S_FLAGS    = 14'h0100,
        S_CSET     = 14'h0200,
        S_CMD_ID   = 14'h0400,
        S_PAYLOAD  = 14'h0800,
        S_CRC_LO   = 14'h1000,
        S_CRC_HI   = 14'h2000
    } step_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* rtl/command_frame_builder_crc8_crc16.sv */
// Top level of the command frame builder.
// A beat goes through the command queue and the current-command register into result.
// Throughput: output runs at one byte per cycle while pop takes it; a payload beat makes 1 byte
// (3 on the last), a header beat 12 to 14 bytes, so input sustains one beat per cycle on payload.
// The QUEUE_DEPTH-entry command queue lets input run ahead while header bytes drain.
// Reset (async, active low) empties the queue and result register and closes any frame.
module command_frame_builder_crc8_crc16
    import cfb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    output logic    full,
    input  item_t   item,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    logic q_push;
    logic q_pop;
    logic q_empty;
    cmd_t q_wr_data;
    cmd_t q_rd_data;

    cfb_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .q_full (full),
        .item   (item),
        .q_push (q_push),
        .q_data (q_wr_data)
    );

    cfb_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .full    (full),
        .empty   (q_empty)
    );

    cfb_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_rd_data),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

/* rtl/cfb_front.sv */
// Front end: accepts input beats, tracks frame position, builds commands.
module cfb_front
    import cfb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  logic  q_full,
    input  item_t item,
    output logic  q_push,
    output cmd_t  q_data
);

    logic       in_frame_reg, in_frame_next;
    logic [9:0] bytes_left_reg, bytes_left_next;
    logic [9:0] len_c;
    logic [9:0] total;
    logic [7:0] len_lo;
    logic [7:0] len_hi;

    localparam logic [7:0] CRC8_AFTER_SYNC = crc8_byte(CRC8_INIT, SYNC_BYTE);

    always_comb
    begin
        len_c  = (item.payload_len > MAX_PAYLOAD) ? MAX_PAYLOAD : item.payload_len;
        total  = len_c + OVERHEAD;
        len_lo = total[7:0];
        len_hi = VERSION_BITS | {6'b0, total[9:8] & LEN_HIGH_MASK};

        q_push = push && !q_full;

        q_data.header       = !in_frame_reg;
        q_data.len_lo       = len_lo;
        q_data.len_hi       = len_hi;
        q_data.hdr_crc      = crc8_byte(crc8_byte(CRC8_AFTER_SYNC, len_lo), len_hi);
        q_data.sender       = item.sender;
        q_data.receiver     = item.receiver;
        q_data.sequence_req = item.sequence_req;
        q_data.msg_flags    = item.msg_flags;
        q_data.command_set  = item.command_set;
        q_data.command_id   = item.command_id;
        q_data.payload_byte = item.payload_byte;

        in_frame_next   = in_frame_reg;
        bytes_left_next = bytes_left_reg;

        if (!in_frame_reg)
        begin
            q_data.has_payload = (len_c != 10'd0);
            q_data.close       = (len_c <= 10'd1);
            if (q_push && len_c > 10'd1)
            begin
                in_frame_next   = 1'b1;
                bytes_left_next = len_c - 10'd1;
            end
        end
        else
        begin
            q_data.has_payload = 1'b1;
            q_data.close       = (bytes_left_reg <= 10'd1);
            if (q_push)
            begin
                bytes_left_next = (bytes_left_reg != 10'd0) ? bytes_left_reg - 10'd1 : 10'd0;
                in_frame_next   = (bytes_left_reg > 10'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            bytes_left_reg <= 10'd0;
        end
        else
        begin
            in_frame_reg   <= in_frame_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

/* rtl/cfb_fifo.sv */
// Short command queue between the front and back ends.
module cfb_fifo
    import cfb_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic full,
    output logic empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb
    begin
        full    = (count_reg == CW'(DEPTH));
        empty   = (count_reg == '0);
        rd_data = mem_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/cfb_back.sv */
// Back end: sequences frame bytes, runs the CRC-16, holds the result register.
module cfb_back
    import cfb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_empty,
    input  cmd_t    q_data,
    output logic    q_pop,
    input  logic    pop,
    output logic    empty,
    output result_t result
);

    cmd_t        cur_reg;
    logic        cur_valid_reg, cur_valid_next;
    step_t       step_reg, step_next;
    logic [15:0] crc_reg, crc_next;
    result_t     result_reg, result_next;
    logic        out_valid_reg, out_valid_next;

    logic        out_ready;
    logic        advance;
    logic        last;
    logic        load;
    logic [15:0] crc_base;

    always_comb
    begin
        out_ready = !out_valid_reg || pop;
        advance   = cur_valid_reg && out_ready;

        result_next.frame_end = 1'b0;
        last      = 1'b0;
        step_next = step_reg;
        case (step_reg)
            S_SYNC:
            begin
                result_next.out_byte = SYNC_BYTE;
                step_next = S_LEN_LO;
            end
            S_LEN_LO:
            begin
                result_next.out_byte = cur_reg.len_lo;
                step_next = S_LEN_HI;
            end
            S_LEN_HI:
            begin
                result_next.out_byte = cur_reg.len_hi;
                step_next = S_HCRC;
            end
            S_HCRC:
            begin
                result_next.out_byte = cur_reg.hdr_crc;
                step_next = S_SENDER;
            end
            S_SENDER:
            begin
                result_next.out_byte = cur_reg.sender;
                step_next = S_RECEIVER;
            end
            S_RECEIVER:
            begin
                result_next.out_byte = cur_reg.receiver;
                step_next = S_SEQ_HI;
            end
            S_SEQ_HI:
            begin
                result_next.out_byte = cur_reg.sequence_req[15:8];
                step_next = S_SEQ_LO;
            end
            S_SEQ_LO:
            begin
                result_next.out_byte = cur_reg.sequence_req[7:0];
                step_next = S_FLAGS;
            end
            S_FLAGS:
            begin
                result_next.out_byte = cur_reg.msg_flags;
                step_next = S_CSET;
            end
            S_CSET:
            begin
                result_next.out_byte = cur_reg.command_set;
                step_next = S_CMD_ID;
            end
            S_CMD_ID:
            begin
                result_next.out_byte = cur_reg.command_id;
                step_next = cur_reg.has_payload ? S_PAYLOAD : S_CRC_LO;
            end
            S_PAYLOAD:
            begin
                result_next.out_byte = cur_reg.payload_byte;
                step_next = S_CRC_LO;
                last      = !cur_reg.close;
            end
            S_CRC_LO:
            begin
                result_next.out_byte = crc_reg[7:0];
                step_next = S_CRC_HI;
            end
            S_CRC_HI:
            begin
                result_next.out_byte  = crc_reg[15:8];
                result_next.frame_end = 1'b1;
                step_next = S_SYNC;
                last      = 1'b1;
            end
            default:
            begin
                result_next.out_byte = 8'h00;
                step_next = S_SYNC;
                last      = 1'b1;
            end
        endcase

        // The CRC restarts on every sync byte.
        crc_base = (step_reg == S_SYNC) ? CRC16_INIT : crc_reg;
        crc_next = crc_reg;
        if (advance)
        begin
            if (step_reg == S_CRC_HI)
            begin
                crc_next = CRC16_INIT;
            end
            else if (step_reg != S_CRC_LO)
            begin
                crc_next = crc16_byte(crc_base, result_next.out_byte);
            end
        end

        load  = !q_empty && (!cur_valid_reg || (advance && last));
        q_pop = load;

        cur_valid_next = cur_valid_reg;
        if (load)
        begin
            cur_valid_next = 1'b1;
            step_next      = q_data.header ? S_SYNC : S_PAYLOAD;
        end
        else if (advance && last)
        begin
            cur_valid_next = 1'b0;
        end
        else if (!advance)
        begin
            step_next = step_reg;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end

        empty  = !out_valid_reg;
        result = result_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= q_data;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= S_SYNC;
            crc_reg       <= CRC16_INIT;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            crc_reg       <= crc_next;
        end
    end

endmodule

/* rtl/cfb_check.sv */
// Port-level checker for the command frame builder, bound to the top level.
`include "command_frame_builder_crc8_crc16_assert.svh"

module cfb_check
    import cfb_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    full,
    input logic    empty,
    input logic    pop,
    input result_t result
);

    logic end_taken;
    logic sync_next;

    assign end_taken = pop && !empty && result.frame_end;
    assign sync_next = !result.frame_end && (result.out_byte == SYNC_BYTE);

    `CFB_ASSERT(a_result_hold, clk, rst_n, (!empty && !pop) |=> (!empty && $stable(result)))
    `CFB_ASSERT(a_sync_after_end, clk, rst_n, end_taken |=> (empty || sync_next))
    `CFB_ASSERT_ANY(a_reset_clear, clk, $rose(rst_n) |-> (empty && !full))

endmodule

bind command_frame_builder_crc8_crc16 cfb_check u_check (.*);

/* verif/tb_command_frame_builder_crc8_crc16.sv */
// Self-checking testbench for the command frame builder: frame bytes, header CRC-8 and CRC-16.
`timescale 1ns / 1ps

module tb_command_frame_builder_crc8_crc16;
    import cfb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CLAMP_TAIL_BEATS = 4;

    logic    clk;
    logic    rst_n;
    logic    push;
    logic    full;
    item_t   item;
    logic    empty;
    logic    pop;
    result_t result;

    // predictor state
    logic        frame_open;
    logic [9:0]  payload_left;
    logic [15:0] frame_crc;
    result_t     expected_bytes[$];

    int snd_idle_pct;
    int rcv_idle_pct;
    int hold_req;
    logic holding;

    int errors;
    int beats_sent;
    int bytes_checked;
    int frames_done;
    int stall_cycles;
    int cycle_cnt;
    result_t want;

    command_frame_builder_crc8_crc16 dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("%0t timeout, %0d bytes still expected", $time, expected_bytes.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [7:0] hdr_crc_step(logic [7:0] c, logic [7:0] b);
        logic [7:0] v;
        v = c ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (v[0])
                v = (v >> 1) ^ CRC8_POLY;
            else
                v = v >> 1;
        end
        return v;
    endfunction

    function automatic logic [15:0] frame_crc_step(logic [15:0] c, logic [7:0] b);
        logic [15:0] v;
        v = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (v[0])
                v = (v >> 1) ^ CRC16_POLY;
            else
                v = v >> 1;
        end
        return v;
    endfunction

    task automatic put_byte(logic [7:0] b);
        result_t r;
        r.out_byte = b;
        r.frame_end = 1'b0;
        expected_bytes.push_back(r);
        frame_crc = frame_crc_step(frame_crc, b);
    endtask

    task automatic close_frame();
        result_t r;
        r.out_byte = frame_crc[7:0];
        r.frame_end = 1'b0;
        expected_bytes.push_back(r);
        r.out_byte = frame_crc[15:8];
        r.frame_end = 1'b1;
        expected_bytes.push_back(r);
        frame_open = 1'b0;
        payload_left = '0;
        frame_crc = CRC16_INIT;
        frames_done++;
    endtask

    task automatic predict_frame_bytes(item_t it);
        logic [9:0] len;
        logic [9:0] total;
        logic [7:0] len_hi;
        logic [7:0] hcrc;
        if (!frame_open)
        begin
            len = (it.payload_len > MAX_PAYLOAD) ? MAX_PAYLOAD : it.payload_len;
            total = len + OVERHEAD;
            len_hi = VERSION_BITS | {6'b0, total[9:8] & LEN_HIGH_MASK};
            hcrc = hdr_crc_step(hdr_crc_step(hdr_crc_step(CRC8_INIT, SYNC_BYTE),
                                             total[7:0]), len_hi);
            frame_crc = CRC16_INIT;
            put_byte(SYNC_BYTE);
            put_byte(total[7:0]);
            put_byte(len_hi);
            put_byte(hcrc);
            put_byte(it.sender);
            put_byte(it.receiver);
            put_byte(it.sequence_req[15:8]);
            put_byte(it.sequence_req[7:0]);
            put_byte(it.msg_flags);
            put_byte(it.command_set);
            put_byte(it.command_id);
            if (len == 10'd0)
                close_frame();
            else
            begin
                put_byte(it.payload_byte);
                payload_left = len - 10'd1;
                frame_open = 1'b1;
                if (payload_left == 10'd0)
                    close_frame();
            end
        end
        else
        begin
            put_byte(it.payload_byte);
            if (payload_left > 10'd0)
                payload_left--;
            if (payload_left == 10'd0)
                close_frame();
        end
    endtask

    // result side: check accepted beats, then decide pop for the next edge
    always @(posedge clk)
    begin
        if (rst_n && push && full)
            stall_cycles++;
        if (rst_n && pop && !empty)
        begin
            if (expected_bytes.size() == 0)
            begin
                errors++;
                $display("%0t unexpected beat: byte %02h end %0b",
                         $time, result.out_byte, result.frame_end);
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (result.out_byte !== want.out_byte || result.frame_end !== want.frame_end)
                begin
                    errors++;
                    $display("%0t mismatch: expected byte %02h end %0b, got byte %02h end %0b",
                             $time, want.out_byte, want.frame_end,
                             result.out_byte, result.frame_end);
                end
                bytes_checked++;
            end
        end
        pop <= !holding && ($urandom_range(99) >= rcv_idle_pct);
    end

    // receiver hold-off, counted here
    initial
    begin
        holding = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                holding <= 1'b1;
                repeat (hold_req) @(posedge clk);
                holding <= 1'b0;
                hold_req = 0;
            end
        end
    end

    task automatic send_beat(item_t it);
        if ($urandom_range(99) < snd_idle_pct)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full);
        beats_sent++;
        predict_frame_bytes(it);
    endtask

    function automatic item_t rand_item();
        item_t it;
        it.sender       = 8'($urandom);
        it.receiver     = 8'($urandom);
        it.sequence_req = 16'($urandom);
        it.msg_flags    = 8'($urandom);
        it.command_set  = 8'($urandom);
        it.command_id   = 8'($urandom);
        it.payload_len  = 10'($urandom);
        it.payload_byte = 8'($urandom);
        return it;
    endfunction

    // first beat as given; later beats carry random payload and ignored header fields
    task automatic send_frame(item_t first);
        int n;
        item_t it;
        n = int'((first.payload_len > MAX_PAYLOAD) ? MAX_PAYLOAD : first.payload_len);
        send_beat(first);
        for (int k = 1; k < n; k++)
        begin
            it = rand_item();
            send_beat(it);
        end
    endtask

    task automatic test_directed();
        item_t it;
        snd_idle_pct = 11;
        rcv_idle_pct = 77;
        it = '0;
        it.payload_byte = 8'hFF;
        send_frame(it);
        it = '1;
        it.payload_len = 10'd0;
        send_frame(it);
        it = rand_item();
        it.payload_len = 10'd1;
        it.payload_byte = 8'h00;
        send_frame(it);
        it = '1;
        it.payload_len = 10'd1;
        send_frame(it);
        it = rand_item();
        it.payload_len = 10'd2;
        send_frame(it);
        it = '0;
        it.payload_len = 10'd3;
        send_frame(it);
        it = '1;
        it.payload_len = 10'd6;
        send_frame(it);
    endtask

    task automatic test_random_frames(int snd_pct, int rcv_pct, int beats);
        int stop_at;
        int r;
        item_t it;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        stop_at = beats_sent + beats;
        while (beats_sent < stop_at)
        begin
            it = rand_item();
            r = $urandom_range(99);
            if (r < 20)
                it.payload_len = 10'd0;
            else if (r < 40)
                it.payload_len = 10'd1;
            else if (r < 85)
                it.payload_len = 10'($urandom_range(2, 8));
            else
                it.payload_len = 10'($urandom_range(9, 24));
            send_frame(it);
        end
    endtask

    task automatic test_backpressure();
        item_t it;
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_req = HOLD_OFF_CYCLES;
        push <= 1'b0;
        @(posedge clk);
        for (int f = 0; f < 4; f++)
        begin
            it = rand_item();
            it.payload_len = 10'($urandom_range(3, 6));
            send_frame(it);
        end
    endtask

    // clamped header plus a few payload beats; the frame is left open
    task automatic test_length_clamp();
        item_t it;
        snd_idle_pct = 0;
        rcv_idle_pct = 5;
        it = rand_item();
        it.payload_len = 10'h3FF;
        send_beat(it);
        for (int k = 0; k < CLAMP_TAIL_BEATS; k++)
        begin
            it = rand_item();
            send_beat(it);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        item = '0;
        hold_req = 0;
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        errors = 0;
        beats_sent = 0;
        bytes_checked = 0;
        frames_done = 0;
        stall_cycles = 0;
        cycle_cnt = 0;
        frame_open = 1'b0;
        payload_left = '0;
        frame_crc = CRC16_INIT;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_frames(11, 77, 15);
        test_random_frames(77, 11, 15);
        test_random_frames(0, 0, 15);
        test_backpressure();
        test_length_clamp();

        push <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d frames from %0d input beats; %0d output bytes checked.",
                 frames_done, beats_sent, bytes_checked);
        $display("Lengths zero, one, short, long and clamped; input held off %0d cycles.",
                 stall_cycles);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
